@@ rtl/teq_pkg.sv @@
package teq_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned TIME_BITS_DEF  = 32;

  // Configuration port
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_SQ_W  = 2 * CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_GAP     = 2'd2;

  localparam logic [CFG_W-1:0]    TIME_WINDOW_RST = 16'd150;
  localparam logic [CFG_W-1:0]    DIST_THR_RST    = 16'd200;
  localparam logic [CFG_W-1:0]    NEW_GAP_RST     = 16'd600;
  localparam logic [CFG_SQ_W-1:0] DIST_SQ_RST     = CFG_SQ_W'(200 * 200);

  localparam int unsigned PRESSURE_W = 8;
  localparam int unsigned VERDICT_W  = 3;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_NO_TOUCH  = 3'd1,
    VERDICT_START_ZERO = 3'd2,
    VERDICT_TOO_SOON  = 3'd3,
    VERDICT_TOO_CLOSE = 3'd4
  } verdict_e;

  // Live configuration, including the squared distance threshold
  typedef struct packed {
    logic [CFG_W-1:0]    time_window;
    logic [CFG_W-1:0]    dist_thr;
    logic [CFG_W-1:0]    new_gap;
    logic [CFG_SQ_W-1:0] dist_thr_sq;
  } cfg_t;

endpackage

@@ rtl/touch_event_qualifier.sv @@
// Touch event qualifier: decides for each touch-panel poll whether it is a new
// touch, giving one result beat per input beat.
//
// Channels: input beats (touched, x, y, pressure, ms timestamp) on in_valid_i /
// in_ready_o; result beats (accepted flag, 3-bit verdict) on out_valid_o /
// out_ready_i. Config registers are written on cfg_we_i with no wait; write
// them only while no beat is in flight.
//
// Path: a beat is loaded into the input register when it is taken, and moves on
// into the result register once that register is free or being drained.
// Throughput: one beat per cycle while the output is not stalled; the qualify logic, including the distance
// squares, sits between those two registers and updates the last-touch state
// as the beat moves on.
//
// Reset: both pipeline stages empty, config back to 150 / 200 / 600, first
// sample pending, last position (-1,-1), last time 0.
//
// Stall: a held result stays in the output register; the input register
// still takes one more beat, then in_ready_o drops until out_ready_i rises.
module touch_event_qualifier #(
  parameter int unsigned COORD_BITS = teq_pkg::COORD_BITS_DEF,
  parameter int unsigned TIME_BITS  = teq_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [teq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [teq_pkg::CFG_W-1:0]        cfg_wdata_i,
  // input beats
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             touched_i,
  input  logic [COORD_BITS-1:0]            pos_x_i,
  input  logic [COORD_BITS-1:0]            pos_y_i,
  input  logic [teq_pkg::PRESSURE_W-1:0]   pressure_i,
  input  logic [TIME_BITS-1:0]             now_ms_i,
  // result beats
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             accepted_o,
  output logic [teq_pkg::VERDICT_W-1:0]    verdict_o
);

  teq_pkg::cfg_t                    cfg;
  teq_pkg::verdict_e                verdict;

  // input register stage
  logic                             s1_valid_q, s1_valid_d;
  logic                             touched_q;
  logic [COORD_BITS-1:0]            pos_x_q;
  logic [COORD_BITS-1:0]            pos_y_q;
  logic [teq_pkg::PRESSURE_W-1:0]   pressure_q;
  logic [TIME_BITS-1:0]             now_ms_q;

  // result register stage
  logic                             out_valid_q, out_valid_d;
  teq_pkg::verdict_e                verdict_q;

  logic                             in_fire, s1_adv;

  // s1 moves on whenever the result register is free or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_ready_i);

  teq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  teq_qualify #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_qualify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .upd_en_i   (s1_adv),
    .touched_i  (touched_q),
    .pos_x_i    (pos_x_q),
    .pos_y_i    (pos_y_q),
    .pressure_i (pressure_q),
    .now_ms_i   (now_ms_q),
    .verdict_o  (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      touched_q  <= touched_i;
      pos_x_q    <= pos_x_i;
      pos_y_q    <= pos_y_i;
      pressure_q <= pressure_i;
      now_ms_q   <= now_ms_i;
    end
    if (s1_adv) begin
      verdict_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign accepted_o  = (verdict_q == teq_pkg::VERDICT_ACCEPT);

endmodule

@@ rtl/teq_cfg_regs.sv @@
module teq_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [teq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [teq_pkg::CFG_W-1:0]      cfg_wdata_i,
  output teq_pkg::cfg_t                  cfg_o
);

  teq_pkg::cfg_t                     cfg_q, cfg_d;
  logic [teq_pkg::CFG_SQ_W-1:0]      wdata_sq;

  // squared once at write time so the datapath only compares
  assign wdata_sq = teq_pkg::CFG_SQ_W'(cfg_wdata_i) * teq_pkg::CFG_SQ_W'(cfg_wdata_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        teq_pkg::REG_TIME_WINDOW: cfg_d.time_window = cfg_wdata_i;
        teq_pkg::REG_DIST_THR: begin
          cfg_d.dist_thr    = cfg_wdata_i;
          cfg_d.dist_thr_sq = wdata_sq;
        end
        teq_pkg::REG_NEW_GAP: cfg_d.new_gap = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_window <= teq_pkg::TIME_WINDOW_RST;
      cfg_q.dist_thr    <= teq_pkg::DIST_THR_RST;
      cfg_q.new_gap     <= teq_pkg::NEW_GAP_RST;
      cfg_q.dist_thr_sq <= teq_pkg::DIST_SQ_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/teq_qualify.sv @@
module teq_qualify #(
  parameter int unsigned COORD_BITS = teq_pkg::COORD_BITS_DEF,
  parameter int unsigned TIME_BITS  = teq_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  teq_pkg::cfg_t                     cfg_i,
  input  logic                              upd_en_i,
  input  logic                              touched_i,
  input  logic [COORD_BITS-1:0]             pos_x_i,
  input  logic [COORD_BITS-1:0]             pos_y_i,
  input  logic [teq_pkg::PRESSURE_W-1:0]    pressure_i,
  input  logic [TIME_BITS-1:0]              now_ms_i,
  output teq_pkg::verdict_e                 verdict_o
);

  localparam int unsigned LAST_W = COORD_BITS + 1;
  localparam int unsigned DX_W   = COORD_BITS + 2;
  localparam int unsigned SQ_W   = 2 * DX_W;
  localparam int unsigned CMP_W  = (SQ_W > teq_pkg::CFG_SQ_W) ? SQ_W : teq_pkg::CFG_SQ_W;
  localparam int unsigned WIN_W  = teq_pkg::CFG_W + 1;

  logic                     first_q, first_d;
  logic [LAST_W-1:0]        last_x_q, last_x_d;
  logic [LAST_W-1:0]        last_y_q, last_y_d;
  logic [TIME_BITS-1:0]     last_time_q, last_time_d;

  logic signed [DX_W-1:0]   dx, dy;
  logic signed [SQ_W-1:0]   sq_x, sq_y;
  logic [SQ_W-1:0]          dist_sq;
  logic [TIME_BITS-1:0]     elapsed;
  logic                     all_zero, too_soon, recent, near;
  logic [WIN_W-1:0]         first_elapsed;
  teq_pkg::verdict_e        verdict;

  // distance to the last accepted touch; last position resets to (-1,-1)
  assign dx = $signed({2'b00, pos_x_i}) - $signed({last_x_q[LAST_W-1], last_x_q});
  assign dy = $signed({2'b00, pos_y_i}) - $signed({last_y_q[LAST_W-1], last_y_q});
  assign sq_x    = dx * dx;
  assign sq_y    = dy * dy;
  assign dist_sq = SQ_W'(sq_x) + SQ_W'(sq_y);
  assign near    = CMP_W'(dist_sq) < CMP_W'(cfg_i.dist_thr_sq);

  // first real sample counts as window + 1, which is never too soon
  assign first_elapsed = WIN_W'(cfg_i.time_window) + WIN_W'(1);
  assign elapsed       = now_ms_i - last_time_q;
  assign too_soon      = !first_q && (elapsed < TIME_BITS'(cfg_i.time_window));
  assign recent        = first_q ? (first_elapsed < WIN_W'(cfg_i.new_gap))
                                 : (elapsed < TIME_BITS'(cfg_i.new_gap));
  assign all_zero      = (pos_x_i == '0) && (pos_y_i == '0) && (pressure_i == '0);

  always_comb begin
    if (!touched_i) begin
      verdict = teq_pkg::VERDICT_NO_TOUCH;
    end else if (first_q && all_zero) begin
      verdict = teq_pkg::VERDICT_START_ZERO;
    end else if (too_soon) begin
      verdict = teq_pkg::VERDICT_TOO_SOON;
    end else if (near && recent) begin
      verdict = teq_pkg::VERDICT_TOO_CLOSE;
    end else begin
      verdict = teq_pkg::VERDICT_ACCEPT;
    end
  end

  always_comb begin
    first_d     = first_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    last_time_d = last_time_q;
    if (upd_en_i) begin
      if (touched_i && !(first_q && all_zero)) begin
        first_d = 1'b0;
      end
      if (verdict == teq_pkg::VERDICT_ACCEPT) begin
        last_x_d    = {1'b0, pos_x_i};
        last_y_d    = {1'b0, pos_y_i};
        last_time_d = now_ms_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      last_x_q    <= '1;
      last_y_q    <= '1;
      last_time_q <= '0;
    end else begin
      first_q     <= first_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      last_time_q <= last_time_d;
    end
  end

  assign verdict_o = verdict;

endmodule

@@ rtl/teq_checker.sv @@
module teq_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_ready_o,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic                           accepted_o,
  input  logic [teq_pkg::VERDICT_W-1:0]  verdict_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(verdict_o) && $stable(accepted_o))
    else $error("result beat changed while stalled");

  // flag and verdict agree
  a_flag_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (verdict_o == teq_pkg::VERDICT_ACCEPT)))
    else $error("accepted flag does not match verdict");

  // input only backs up behind a stalled, full output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // pipeline empty once reset has been seen at an edge
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("pipeline not empty in reset");

endmodule

bind touch_event_qualifier teq_checker u_teq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .accepted_o  (accepted_o),
  .verdict_o   (verdict_o)
);
